[design/cve_pkg.sv]
package cve_pkg;

  localparam int MaxNameLen  = 32;
  localparam int NameBits    = MaxNameLen * 8;
  localparam int LenW        = 6;
  localparam int ShiftW      = 5;

  localparam logic [2:0] CFG_NAME_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_NAME_BYTES_A = 3'd1;
  localparam logic [2:0] CFG_NAME_BYTES_B = 3'd2;
  localparam logic [2:0] CFG_NAME_BYTES_C = 3'd3;
  localparam logic [2:0] CFG_NAME_BYTES_D = 3'd4;
  localparam logic [2:0] CFG_STOP_AT_BAR  = 3'd5;

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_CHECK  = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_FIRST  = 3'd3;
  localparam logic [2:0] PH_VALUE  = 3'd4;
  localparam logic [2:0] PH_HIT    = 3'd5;
  localparam logic [2:0] PH_MISS   = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_BAR   = 8'h7c;

  typedef struct packed {
    logic [NameBits-1:0] win;
    logic [LenW-1:0]     cnt;
    logic                hit;
  } match_res_t;

endpackage

[design/cve_match.sv]
module cve_match
  import cve_pkg::*;
(
  input  logic [NameBits-1:0] win_q,
  input  logic [LenW-1:0]     cnt_q,
  input  logic                restart,
  input  logic [7:0]          byte_in,
  input  logic [LenW-1:0]     name_len,
  input  logic [NameBits-1:0] name_bits,
  output match_res_t          res
);

  logic [NameBits-1:0] win_base;
  logic [LenW-1:0]     cnt_base;
  logic [NameBits-1:0] win_new;
  logic [NameBits-1:0] win_rev;
  logic [NameBits-1:0] aligned;
  logic [NameBits-1:0] mask;
  logic [LenW-1:0]     len_eff;
  logic [LenW-1:0]     cnt_new;
  logic [ShiftW-1:0]   sh;

  always_comb begin
    win_base = restart ? '0 : win_q;
    cnt_base = restart ? '0 : cnt_q;
    win_new  = {win_base[NameBits-9:0], byte_in};
    cnt_new  = (cnt_base < LenW'(MaxNameLen)) ? cnt_base + 1'b1 : cnt_base;

    if (name_len == '0) begin
      len_eff = LenW'(1);
    end else if (name_len > LenW'(MaxNameLen)) begin
      len_eff = LenW'(MaxNameLen);
    end else begin
      len_eff = name_len;
    end
    sh = ShiftW'(LenW'(MaxNameLen) - len_eff);

    for (int k = 0; k < MaxNameLen; k++) begin
      win_rev[k*8 +: 8] = win_new[(MaxNameLen-1-k)*8 +: 8];
    end

    aligned = win_rev >> {sh, 3'b000};
    mask    = {NameBits{1'b1}} >> {sh, 3'b000};

    res.win = win_new;
    res.cnt = cnt_new;
    res.hit = (cnt_new >= len_eff) && (((aligned ^ name_bits) & mask) == '0);
  end

endmodule

[design/cookie_value_extractor_core.sv]
// A result item for an accepted header byte is registered and appears in the cycle after the byte is accepted.
// Throughput: one header byte per cycle; the 32-byte window compare is a
// single combinational pass, and in_tready stays high while the result register is free
// or being drained.
// Reset (rst_n low, synchronous): search restarts, result register empties,
// registers return to name_length 1, name zero, bar mode off.
module cookie_value_extractor_core
  import cve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] header_byte
  input  logic        in_tlast,   // end_of_header
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value_byte, [8] found, [15:9] zero
  output logic        out_tuser,  // byte_valid
  output logic        out_tlast,  // done_res
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  logic [LenW-1:0]     name_len_r;
  logic [NameBits-1:0] name_r;
  logic                bar_mode_r;

  logic [2:0]          phase_r, phase_nxt;
  logic [NameBits-1:0] win_r;
  logic [LenW-1:0]     cnt_r, cnt_nxt;

  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_bv_r, out_done_r, out_found_r;

  logic                in_acc;
  logic [7:0]          b;
  logic                is_bar, restart, emit, found, give;
  logic                upd_win;
  match_res_t          mres;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign is_bar    = bar_mode_r && (b == CH_BAR);
  assign restart   = (phase_r == PH_CHECK);

  cve_match u_match (
    .win_q     (win_r),
    .cnt_q     (cnt_r),
    .restart   (restart),
    .byte_in   (b),
    .name_len  (name_len_r),
    .name_bits (name_r),
    .res       (mres)
  );

  always_comb begin
    phase_nxt = phase_r;
    emit      = 1'b0;
    upd_win   = 1'b0;
    case (phase_r)
      PH_SEARCH: begin
        upd_win = 1'b1;
        if (mres.hit) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        if (b == CH_EQ) begin
          phase_nxt = PH_FIRST;
        end else if (b == CH_SPACE) begin
          phase_nxt = PH_SKIP;
        end else begin
          upd_win   = 1'b1;
          phase_nxt = mres.hit ? PH_CHECK : PH_SEARCH;
        end
      end
      PH_SKIP: begin
        if (b == CH_EQ) phase_nxt = PH_FIRST;
      end
      PH_FIRST: begin
        if (b == CH_SEMI || b == CH_SPACE) begin
          phase_nxt = PH_MISS;
        end else if (is_bar) begin
          phase_nxt = PH_HIT;
        end else begin
          emit      = 1'b1;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (b == CH_SEMI || b == CH_SPACE || is_bar) phase_nxt = PH_HIT;
        else emit = 1'b1;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
    found   = (phase_nxt == PH_VALUE) || (phase_nxt == PH_HIT);
    give    = emit || in_tlast;
    cnt_nxt = upd_win ? mres.cnt : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_len_r <= LenW'(1);
      name_r     <= '0;
      bar_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_NAME_LENGTH:  name_len_r      <= cfg_wdata[LenW-1:0];
        CFG_NAME_BYTES_A: name_r[63:0]    <= cfg_wdata;
        CFG_NAME_BYTES_B: name_r[127:64]  <= cfg_wdata;
        CFG_NAME_BYTES_C: name_r[191:128] <= cfg_wdata;
        CFG_NAME_BYTES_D: name_r[255:192] <= cfg_wdata;
        CFG_STOP_AT_BAR:  bar_mode_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      cnt_r   <= '0;
    end else if (in_acc) begin
      if (in_tlast) begin
        phase_r <= PH_SEARCH;
        cnt_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && upd_win) begin
      win_r <= mres.win;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && give) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && give) begin
      out_byte_r  <= emit ? b : 8'h00;
      out_bv_r    <= emit;
      out_done_r  <= in_tlast;
      out_found_r <= in_tlast && found;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_found_r, out_byte_r};
  assign out_tuser  = out_bv_r;
  assign out_tlast  = out_done_r;

endmodule

[design/cve_checker.sv]
module cve_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_item_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("result item with neither value byte nor done");

  a_found_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[8])
    else $error("found flag outside done item");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

bind cookie_value_extractor_core cve_checker u_cve_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/sv/cookie_value_extractor_core_test.sv]
module cookie_value_extractor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cve_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } header_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done;
    logic       found;
  } cookie_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_addr = CFG_NAME_LENGTH;
  logic [63:0] cfg_wdata = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  cookie_value_extractor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and the parse state
  logic [LenW-1:0] name_len_q = 6'd1;
  logic [63:0]     name_word [4] = '{default: '0};
  logic            bar_mode = 1'b0;
  logic [2:0]      phase_q = PH_SEARCH;
  logic [7:0]      window_q [MaxNameLen] = '{default: '0};
  int unsigned     seen_q = 0;

  header_item_t pending_items [$];
  cookie_res_t  expected_values [$];
  header_item_t next_item;
  cookie_res_t  want_res;

  int unsigned items_issued = 0;
  int unsigned items_taken = 0;
  int unsigned results_predicted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned src_hold = 0;
  int unsigned sink_hold = 0;
  bit          calm = 1'b0;

  function automatic int unsigned name_span();
    if (name_len_q == 0) return 1;
    if (name_len_q > MaxNameLen) return MaxNameLen;
    return 32'(name_len_q);
  endfunction

  function automatic logic [7:0] name_char(int unsigned i);
    return name_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic void restart_search();
    foreach (window_q[k]) window_q[k] = '0;
    seen_q = 0;
  endfunction

  function automatic bit shift_in(logic [7:0] b);
    int unsigned span;
    int          k;
    span = name_span();
    for (k = MaxNameLen - 1; k > 0; k--) window_q[k] = window_q[k - 1];
    window_q[0] = b;
    if (seen_q < MaxNameLen) seen_q++;
    if (seen_q < span) return 1'b0;
    for (k = 0; k < span; k++) begin
      if (window_q[span - 1 - k] != name_char(k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit advance_parser(logic [7:0] b, logic last);
    bit          at_bar;
    bit          emit;
    bit          found;
    cookie_res_t res;
    at_bar = bar_mode && b == CH_BAR;
    emit = 1'b0;
    case (phase_q)
      PH_SEARCH: begin
        if (shift_in(b)) phase_q = PH_CHECK;
      end
      PH_CHECK: begin
        if (b == CH_EQ) begin
          phase_q = PH_FIRST;
        end else if (b == CH_SPACE) begin
          phase_q = PH_SKIP;
        end else begin
          restart_search();
          phase_q = shift_in(b) ? PH_CHECK : PH_SEARCH;
        end
      end
      PH_SKIP: begin
        if (b == CH_EQ) phase_q = PH_FIRST;
      end
      PH_FIRST: begin
        if (b == CH_SEMI || b == CH_SPACE) begin
          phase_q = PH_MISS;
        end else if (at_bar) begin
          phase_q = PH_HIT;
        end else begin
          emit = 1'b1;
          phase_q = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (b == CH_SEMI || b == CH_SPACE || at_bar) phase_q = PH_HIT;
        else emit = 1'b1;
      end
      default: begin
      end
    endcase
    found = phase_q == PH_VALUE || phase_q == PH_HIT;
    if (emit || last) begin
      res.value_byte = emit ? b : 8'h00;
      res.byte_valid = emit;
      res.done = last;
      res.found = last && found;
      expected_values.push_back(res);
    end
    if (last) begin
      phase_q = PH_SEARCH;
      restart_search();
    end
    return emit || last;
  endfunction

  task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_count < 100) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        items_taken <= items_taken + 1;
        if (advance_parser(in_tdata, in_tlast)) results_predicted <= results_predicted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (src_hold != 0) begin
          src_hold <= src_hold - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          src_hold <= $urandom_range(0, 18);
          in_tvalid <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_item.data;
          in_tlast <= next_item.last;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_values.size() == 0) begin
        flag_mismatch("unexpected item", out_tdata[7:0], 8'h00);
      end else begin
        want_res = expected_values.pop_front();
        results_checked <= results_checked + 1;
        if (out_tdata[7:0] !== want_res.value_byte) begin
          flag_mismatch("value_byte", out_tdata[7:0], want_res.value_byte);
        end
        if (out_tuser !== want_res.byte_valid) begin
          flag_mismatch("byte_valid", 8'(out_tuser), 8'(want_res.byte_valid));
        end
        if (out_tlast !== want_res.done) begin
          flag_mismatch("done_res", 8'(out_tlast), 8'(want_res.done));
        end
        if (out_tdata[8] !== want_res.found) begin
          flag_mismatch("found", 8'(out_tdata[8]), 8'(want_res.found));
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_hold <= $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_NAME_LENGTH:  name_len_q = val[LenW-1:0];
      CFG_NAME_BYTES_A: name_word[0] = val;
      CFG_NAME_BYTES_B: name_word[1] = val;
      CFG_NAME_BYTES_C: name_word[2] = val;
      CFG_NAME_BYTES_D: name_word[3] = val;
      CFG_STOP_AT_BAR:  bar_mode = val[0];
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    while (items_taken != items_issued || results_checked != results_predicted) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] printable_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[k * 8 +: 8] = 8'($urandom_range(8'h21, 8'h7e));
    return w;
  endfunction

  function automatic logic [63:0] any_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_EQ;
      2: return CH_SEMI;
      3: return CH_BAR;
      4: return name_char($urandom_range(0, name_span() - 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] value_char();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  task automatic queue_byte(logic [7:0] b, logic last);
    pending_items.push_back('{data: b, last: last});
    items_issued++;
  endtask

  task automatic queue_text(string s, logic close);
    for (int k = 0; k < s.len(); k++) queue_byte(s[k], close && k == s.len() - 1);
  endtask

  task automatic add_filler(ref logic [7:0] hdr [$]);
    repeat ($urandom_range(1, 4)) hdr.push_back(8'($urandom_range(8'h61, 8'h7a)));
    hdr.push_back(CH_EQ);
    repeat ($urandom_range(0, 3)) hdr.push_back(value_char());
    hdr.push_back(CH_SEMI);
    hdr.push_back(CH_SPACE);
  endtask

  task automatic queue_random_header();
    logic [7:0]  hdr [$];
    int unsigned span;
    int unsigned kind;
    int unsigned n;
    int          k;
    span = name_span();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) hdr.push_back(noise_char());
    end else begin
      repeat ($urandom_range(0, 2)) add_filler(hdr);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, span - 1);
        for (k = 0; k < n; k++) hdr.push_back(name_char(k));
      end
      for (k = 0; k < span; k++) hdr.push_back(name_char(k));
      if (kind == 9) begin
        hdr.push_back(noise_char());
      end else if (kind != 8) begin
        if ($urandom_range(0, 3) == 0) begin
          hdr.push_back(CH_SPACE);
          repeat ($urandom_range(0, 2)) hdr.push_back(noise_char());
        end
        hdr.push_back(CH_EQ);
        repeat ($urandom_range(0, 6)) hdr.push_back(value_char());
        case ($urandom_range(0, 3))
          0: hdr.push_back(CH_SEMI);
          1: hdr.push_back(CH_SPACE);
          2: hdr.push_back(CH_BAR);
          default: begin
          end
        endcase
      end
      if (kind != 8) begin
        repeat ($urandom_range(0, 2)) add_filler(hdr);
      end
    end
    for (k = 0; k < hdr.size(); k++) queue_byte(hdr[k], k == hdr.size() - 1);
  endtask

  task automatic set_up_stage(int stage);
    case (stage)
      1: begin
        write_reg(CFG_NAME_LENGTH, 64'd2);
        write_reg(CFG_NAME_BYTES_A, {48'(any_word()), 8'h64, 8'h69});
        write_reg(CFG_NAME_BYTES_B, any_word());
        write_reg(CFG_NAME_BYTES_C, any_word());
        write_reg(CFG_NAME_BYTES_D, any_word());
        write_reg(CFG_STOP_AT_BAR, 64'd0);
      end
      2: begin
        write_reg(CFG_STOP_AT_BAR, 64'd1);
      end
      3: begin
        write_reg(CFG_NAME_LENGTH, 64'(MaxNameLen));
        write_reg(CFG_NAME_BYTES_A, any_word());
        write_reg(CFG_NAME_BYTES_B, any_word());
        write_reg(CFG_NAME_BYTES_C, any_word());
        write_reg(CFG_NAME_BYTES_D, any_word());
        write_reg(CFG_STOP_AT_BAR, 64'd0);
      end
      4: begin
        write_reg(CFG_NAME_LENGTH, 64'd0);
        write_reg(CFG_NAME_BYTES_A, any_word());
        write_reg(CFG_STOP_AT_BAR, 64'd1);
      end
      5: begin
        write_reg(CFG_NAME_LENGTH, 64'd63);
        write_reg(CFG_NAME_BYTES_A, printable_word());
        write_reg(CFG_NAME_BYTES_B, printable_word());
        write_reg(CFG_NAME_BYTES_C, printable_word());
        write_reg(CFG_NAME_BYTES_D, printable_word());
        write_reg(CFG_STOP_AT_BAR, 64'd0);
      end
      6: begin
        write_reg(CFG_NAME_LENGTH, 64'($urandom_range(3, MaxNameLen - 1)));
        write_reg(CFG_NAME_BYTES_A, any_word());
        write_reg(CFG_NAME_BYTES_B, printable_word());
        write_reg(CFG_NAME_BYTES_C, any_word());
        write_reg(CFG_NAME_BYTES_D, printable_word());
        write_reg(CFG_STOP_AT_BAR, 64'($urandom_range(0, 1)));
      end
      7: begin
        write_reg(CFG_NAME_LENGTH, 64'd1);
        write_reg(CFG_NAME_BYTES_A, printable_word());
        write_reg(CFG_STOP_AT_BAR, 64'd1);
      end
      default: begin
        write_reg(CFG_NAME_LENGTH, 64'($urandom_range(1, 12)));
        write_reg(CFG_NAME_BYTES_A, printable_word());
        write_reg(CFG_NAME_BYTES_B, printable_word());
        write_reg(CFG_STOP_AT_BAR, 64'($urandom_range(0, 1)));
      end
    endcase
  endtask

  initial begin
    int stage;
    int unsigned mark;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (stage = 0; stage < 9; stage++) begin
      if (stage != 0) begin
        wait_idle();
        set_up_stage(stage);
      end
      if (stage == 1) begin
        queue_text("id", 1'b1);
        queue_text("id z", 1'b1);
        queue_text("id=;", 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_text("id=", 1'b0);
        queue_byte(8'hff, 1'b1);
        queue_text("id =v", 1'b1);
      end
      if (stage == 2) queue_text("id=|x", 1'b1);
      if (stage == 8) calm = 1'b1;
      mark = items_issued;
      while (items_issued - mark < 100) queue_random_header();
    end
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_values.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
design/cve_pkg.sv
design/cve_match.sv
design/cookie_value_extractor_core.sv
design/cve_checker.sv
tb/sv/cookie_value_extractor_core_test.sv
